FILE: hdl/rcs_pkg.sv
// shared types and constants for the raycast column setup pipeline
// used by rcs_dist_div, rcs_slice_div and raycast_column_setup_core
`default_nettype none
package rcs_pkg;

    localparam int TEX_WIDTH = 64;
    localparam int TEX_BITS  = 11;

    localparam logic [10:0] SCREEN_H_RESET = 11'd480;

    localparam logic [1:0] FORCE_NONE = 2'd0;
    localparam logic [1:0] FORCE_ZERO = 2'd1;
    localparam logic [1:0] FORCE_MAX  = 2'd2;

    localparam logic [23:0] DIST_MAX  = 24'hFFFFFF;
    localparam logic [15:0] SLICE_MAX = 16'hFFFF;

    typedef struct packed {
        logic [11:0]        column;
        logic [23:0]        other_cam;
        logic signed [17:0] other_ray;
        logic               mirror;
    } side_t;

    typedef struct packed {
        logic        vld;
        side_t       sd;
        logic [1:0]  force_code;
        logic [17:0] ar;
        logic [16:0] rem;
        logic [23:0] dlo;
        logic [23:0] q;
    } da_t;

    typedef struct packed {
        logic        vld;
        side_t       sd;
        logic [23:0] wdist;
    } dist_t;

    typedef struct packed {
        logic        vld;
        side_t       sd;
        logic [23:0] wdist;
        logic        sat;
        logic [23:0] rem;
        logic [15:0] q;
    } db_t;

    typedef struct packed {
        logic        vld;
        side_t       sd;
        logic [23:0] wdist;
        logic [15:0] slice;
    } slice_t;

endpackage
`default_nettype wire

FILE: hdl/rcs_dist_div.sv
// perpendicular distance divider, one quotient bit per pipeline stage
// depends on rcs_pkg
`default_nettype none
module rcs_dist_div (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  rcs_pkg::da_t      din,
    output rcs_pkg::dist_t    dout
);
    import rcs_pkg::*;

    localparam int STEPS = 24;

    da_t   stg_reg [0:STEPS-1];
    da_t   stg_next [0:STEPS-1];
    dist_t dout_reg;
    dist_t dout_next;

    always_comb
    begin
        logic [17:0] t;
        da_t         cur;
        for (int i = 0; i < STEPS; i++) begin
            cur = (i == 0) ? din : stg_reg[i-1];
            t = {cur.rem, cur.dlo[23]};
            stg_next[i] = cur;
            stg_next[i].dlo = {cur.dlo[22:0], 1'b0};
            if (t >= cur.ar) begin
                stg_next[i].rem = 17'(t - cur.ar);
                stg_next[i].q   = {cur.q[22:0], 1'b1};
            end else begin
                stg_next[i].rem = t[16:0];
                stg_next[i].q   = {cur.q[22:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        dout_next.vld = stg_reg[STEPS-1].vld;
        dout_next.sd  = stg_reg[STEPS-1].sd;
        case (stg_reg[STEPS-1].force_code)
            FORCE_ZERO: dout_next.wdist = '0;
            FORCE_MAX:  dout_next.wdist = DIST_MAX;
            default:    dout_next.wdist = stg_reg[STEPS-1].q;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < STEPS; i++) stg_reg[i] <= '0;
            dout_reg <= '0;
        end else if (en) begin
            for (int i = 0; i < STEPS; i++) stg_reg[i] <= stg_next[i];
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule
`default_nettype wire

FILE: hdl/rcs_slice_div.sv
// slice height divider, screen height over distance, one bit per stage
// depends on rcs_pkg
`default_nettype none
module rcs_slice_div (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         en,
    input  wire logic [10:0]  screen_h,
    input  rcs_pkg::dist_t    din,
    output rcs_pkg::slice_t   dout
);
    import rcs_pkg::*;

    localparam int STEPS = 16;

    db_t    first_reg;
    db_t    first_next;
    db_t    stg_reg [0:STEPS-1];
    db_t    stg_next [0:STEPS-1];
    slice_t dout_reg;
    slice_t dout_next;

    always_comb
    begin
        first_next.vld   = din.vld;
        first_next.sd    = din.sd;
        first_next.wdist = din.wdist;
        first_next.sat   = (screen_h != 11'd0) && ({13'd0, screen_h} >= din.wdist);
        first_next.rem   = {13'd0, screen_h};
        first_next.q     = '0;
    end

    always_comb
    begin
        logic [24:0] t;
        db_t         cur;
        for (int i = 0; i < STEPS; i++) begin
            cur = (i == 0) ? first_reg : stg_reg[i-1];
            t = {cur.rem, 1'b0};
            stg_next[i] = cur;
            if (t >= {1'b0, cur.wdist}) begin
                stg_next[i].rem = 24'(t - {1'b0, cur.wdist});
                stg_next[i].q   = {cur.q[14:0], 1'b1};
            end else begin
                stg_next[i].rem = t[23:0];
                stg_next[i].q   = {cur.q[14:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        dout_next.vld   = stg_reg[STEPS-1].vld;
        dout_next.sd    = stg_reg[STEPS-1].sd;
        dout_next.wdist = stg_reg[STEPS-1].wdist;
        dout_next.slice = stg_reg[STEPS-1].sat ? SLICE_MAX : stg_reg[STEPS-1].q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            first_reg <= '0;
            for (int i = 0; i < STEPS; i++) stg_reg[i] <= '0;
            dout_reg <= '0;
        end else if (en) begin
            first_reg <= first_next;
            for (int i = 0; i < STEPS; i++) stg_reg[i] <= stg_next[i];
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;

endmodule
`default_nettype wire

FILE: hdl/raycast_column_setup_core.sv
// raycaster wall column projection: distance, slice height, rows, texture column
// depends on rcs_pkg, rcs_dist_div, rcs_slice_div
//
// channel   dir  handshake          content
// s_axis    in   s_tvalid/s_tready  one ray hit word per column
// m_axis    out  m_tvalid/m_tready  one column setup word per ray
// cfg       in   cfg_valid/cfg_ready screen height register
//
// one word enters per cycle while the output is not stalled; words pass through
// the two bit-serial divider pipelines (24 distance stages, then slice stages)
// plus setup and output stages. a stalled output freezes the whole pipeline in
// place, nothing is lost. reset clears all valid bits and loads screen height 480.
`default_nettype none
module raycast_column_setup_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output wire logic         s_tready,
    // column, cell_x, cell_y, step_dir_x, step_dir_y, cam_x, cam_y, ray_x, ray_y
    input  wire logic [119:0] s_tdata,
    // hit_side
    input  wire logic         s_tuser,
    output wire logic         m_tvalid,
    input  wire logic         m_tready,
    // column_out, wall_distance, slice_height, row_start, row_end, tex_column
    output wire logic [79:0]  m_tdata,
    input  wire logic         cfg_valid,
    output wire logic         cfg_ready,
    input  wire logic [10:0]  cfg_data
);
    import rcs_pkg::*;

    typedef struct packed {
        logic               vld;
        side_t              sd;
        logic signed [25:0] num;
        logic signed [17:0] ray;
    } num_t;

    typedef struct packed {
        logic               vld;
        logic [11:0]        column;
        logic               mirror;
        logic [15:0]        cam_lo;
        logic [23:0]        wdist;
        logic [15:0]        slice;
        logic [10:0]        rs;
        logic [10:0]        re;
        logic signed [42:0] prod;
    } mul_t;

    logic [10:0] screen_h_reg;
    logic        en;
    num_t        num_reg, num_next;
    da_t         da_reg, da_next;
    dist_t       dist_w;
    slice_t      slice_w;
    mul_t        mul_reg, mul_next;
    logic        out_vld_reg;
    logic [79:0] out_data_reg, out_data_next;

    logic [11:0]        in_column;
    logic [7:0]         in_cell_x, in_cell_y;
    logic [1:0]         in_step_x, in_step_y;
    logic [23:0]        in_cam_x, in_cam_y;
    logic signed [17:0] in_ray_x, in_ray_y;

    assign in_column = s_tdata[11:0];
    assign in_cell_x = s_tdata[19:12];
    assign in_cell_y = s_tdata[27:20];
    assign in_step_x = s_tdata[29:28];
    assign in_step_y = s_tdata[31:30];
    assign in_cam_x  = s_tdata[55:32];
    assign in_cam_y  = s_tdata[79:56];
    assign in_ray_x  = s_tdata[97:80];
    assign in_ray_y  = s_tdata[115:98];

    assign en        = !out_vld_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            screen_h_reg <= SCREEN_H_RESET;
        end else if (cfg_valid) begin
            screen_h_reg <= cfg_data;
        end
    end

    // wall offset numerator, (1 - step) taken modulo 4
    always_comb
    begin
        logic [7:0]  cell_v;
        logic [23:0] cam;
        logic [1:0]  k;
        num_next.vld = s_tvalid;
        if (!s_tuser) begin
            cell_v = in_cell_x;
            cam    = in_cam_x;
            k      = 2'(2'd1 - in_step_x);
            num_next.ray          = in_ray_x;
            num_next.sd.other_cam = in_cam_y;
            num_next.sd.other_ray = in_ray_y;
            num_next.sd.mirror    = in_ray_x > 18'sd0;
        end else begin
            cell_v = in_cell_y;
            cam    = in_cam_y;
            k      = 2'(2'd1 - in_step_y);
            num_next.ray          = in_ray_y;
            num_next.sd.other_cam = in_cam_x;
            num_next.sd.other_ray = in_ray_x;
            num_next.sd.mirror    = in_ray_y < 18'sd0;
        end
        num_next.sd.column = in_column;
        num_next.num = $signed({2'b00, cell_v, 16'd0}) - $signed({2'b00, cam})
                     + $signed({9'd0, k, 15'd0});
    end

    always_comb
    begin
        logic [24:0] an;
        logic [17:0] ar;
        an = num_reg.num[25] ? 25'(-num_reg.num) : num_reg.num[24:0];
        ar = num_reg.ray[17] ? 18'(-num_reg.ray) : num_reg.ray;
        da_next.vld = num_reg.vld;
        da_next.sd  = num_reg.sd;
        da_next.ar  = ar;
        da_next.rem = an[24:8];
        da_next.dlo = {an[7:0], 16'd0};
        da_next.q   = '0;
        if (num_reg.num == 26'sd0)
            da_next.force_code = FORCE_ZERO;
        else if (num_reg.ray == 18'sd0)
            da_next.force_code = FORCE_MAX;
        else if (num_reg.num[25] != num_reg.ray[17])
            da_next.force_code = FORCE_ZERO;
        else if ({1'b0, an} >= {ar, 8'd0})
            da_next.force_code = FORCE_MAX;
        else
            da_next.force_code = FORCE_NONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            num_reg <= '0;
            da_reg  <= '0;
        end else if (en) begin
            num_reg <= num_next;
            da_reg  <= da_next;
        end
    end

    rcs_dist_div u_dist_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .din   (da_reg),
        .dout  (dist_w)
    );

    rcs_slice_div u_slice_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .screen_h (screen_h_reg),
        .din      (dist_w),
        .dout     (slice_w)
    );

    // zero screen height gives a zero slice
    always_comb
    begin
        logic [9:0]  half;
        logic [15:0] slice_v;
        logic [14:0] s2;
        logic [15:0] re_w;
        half    = screen_h_reg[10:1];
        slice_v = (screen_h_reg == 11'd0) ? 16'd0 : slice_w.slice;
        s2      = slice_v[15:1];
        re_w    = {6'd0, half} + {1'b0, s2};
        mul_next.vld    = slice_w.vld;
        mul_next.column = slice_w.sd.column;
        mul_next.mirror = slice_w.sd.mirror;
        mul_next.cam_lo = slice_w.sd.other_cam[15:0];
        mul_next.wdist  = slice_w.wdist;
        mul_next.slice  = slice_v;
        mul_next.rs     = (s2 > {5'd0, half}) ? 11'd0 : 11'({5'd0, half} - s2);
        if (screen_h_reg == 11'd0)
            mul_next.re = 11'd0;
        else if (re_w >= {5'd0, screen_h_reg})
            mul_next.re = 11'(screen_h_reg - 11'd1);
        else
            mul_next.re = re_w[10:0];
        mul_next.prod = $signed({1'b0, slice_w.wdist}) * slice_w.sd.other_ray;
    end

    always_comb
    begin
        logic [31:0]           frac;
        logic [32+TEX_BITS-1:0] scaled;
        logic [TEX_BITS-1:0]   tex;
        frac   = {mul_reg.cam_lo, 16'd0} + 32'(mul_reg.prod);
        scaled = (32+TEX_BITS)'(frac) * (32+TEX_BITS)'(TEX_WIDTH);
        tex    = scaled[32+TEX_BITS-1:32];
        if (mul_reg.mirror)
            tex = TEX_BITS'(TEX_WIDTH) - tex - TEX_BITS'(1);
        out_data_next = {tex[5:0], mul_reg.re, mul_reg.rs, mul_reg.slice,
                         mul_reg.wdist, mul_reg.column};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mul_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            mul_reg     <= mul_next;
            out_vld_reg <= mul_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    a_rows_order: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && screen_h_reg != 11'd0) |->
            (m_tdata[62:52] <= m_tdata[73:63] && m_tdata[73:63] < screen_h_reg))
        else $error("row_start/row_end out of order or off screen");

    a_zero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && screen_h_reg != 11'd0 && m_tdata[35:12] == 24'd0) |->
            (m_tdata[51:36] == SLICE_MAX))
        else $error("zero distance must saturate slice height");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |-> (!s_tready ##1 (m_tvalid && $stable(m_tdata))))
        else $error("pipeline advanced while output stalled");

endmodule
`default_nettype wire

FILE: tb/raycast_column_setup_checker.sv
// checker for raycast_column_setup_core: watches the ray, result and cfg channels
// predicts each column setup word and compares it field by field; depends on rcs_pkg
`default_nettype none
module raycast_column_setup_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [119:0] s_tdata,
    input  wire logic         s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [79:0]  m_tdata,
    input  wire logic         cfg_valid,
    input  wire logic         cfg_ready,
    input  wire logic [10:0]  cfg_data,
    output int                errors,
    output int                pending
);
    import rcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [5:0]  tex_column;
        logic [10:0] row_end;
        logic [10:0] row_start;
        logic [15:0] slice_height;
        logic [23:0] wall_distance;
        logic [11:0] column_out;
    } setup_word_t;

    setup_word_t expected_setups[$];
    logic [10:0] screen_h;

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic setup_word_t project_column(logic [119:0] d, logic side,
                                                   logic [10:0] h);
        setup_word_t r;
        longint num, ray, ocam, oray, mray, q, s;
        longint half, sl2, re;
        logic [23:0] wdist;
        logic [63:0] hit;
        logic [5:0] tex;
        if (!side)
        begin
            num  = longint'(d[19:12]) * 65536 - longint'(d[55:32])
                 + (1 - longint'($signed(d[29:28]))) * 32768;
            ray  = longint'($signed(d[97:80]));
            ocam = longint'(d[79:56]);
            oray = longint'($signed(d[115:98]));
        end
        else
        begin
            num  = longint'(d[27:20]) * 65536 - longint'(d[79:56])
                 + (1 - longint'($signed(d[31:30]))) * 32768;
            ray  = longint'($signed(d[115:98]));
            ocam = longint'(d[55:32]);
            oray = longint'($signed(d[97:80]));
        end
        mray = ray;
        if (num == 0)
            wdist = 24'd0;
        else if (ray == 0)
            wdist = DIST_MAX;
        else if ((num < 0) != (ray < 0))
            wdist = 24'd0;
        else
        begin
            q = (abs64(num) << 16) / abs64(ray);
            wdist = q > 64'hFFFFFF ? DIST_MAX : q[23:0];
        end
        if (wdist == 0)
            s = 65535;
        else
        begin
            s = (longint'(h) << 16) / longint'(wdist);
            if (s > 65535)
                s = 65535;
        end
        if (h == 0)
            s = 0;
        half = longint'(h) / 2;
        sl2  = s / 2;
        re   = half + sl2;
        if (h == 0)
            re = 0;
        else if (re >= h)
            re = longint'(h) - 1;
        hit = (ocam << 16) + longint'(wdist) * oray;
        tex = hit[31:26];
        if ((!side && mray > 0) || (side && mray < 0))
            tex = 6'd63 - tex;
        r.column_out    = d[11:0];
        r.wall_distance = wdist;
        r.slice_height  = s[15:0];
        r.row_start     = sl2 > half ? 11'd0 : 11'(half - sl2);
        r.row_end       = re[10:0];
        r.tex_column    = tex;
        return r;
    endfunction

    task automatic report_field(string name, longint unsigned exp_v, longint unsigned got_v);
        errors++;
        if (errors <= 10)
            $display("%0t mismatch %s: expected %0d, got %0d", $realtime, name, exp_v, got_v);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        setup_word_t e, g;
        if (!rst_n)
        begin
            expected_setups.delete();
            screen_h = SCREEN_H_RESET;
            errors   = 0;
            pending  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                screen_h = cfg_data;
            if (s_tvalid && s_tready)
                expected_setups.push_back(project_column(s_tdata, s_tuser, screen_h));
            if (m_tvalid && m_tready)
            begin
                g = m_tdata;
                if (expected_setups.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t unexpected word %h", $realtime, m_tdata);
                end
                else
                begin
                    e = expected_setups.pop_front();
                    if (e.column_out != g.column_out)
                        report_field("column_out", e.column_out, g.column_out);
                    if (e.wall_distance != g.wall_distance)
                        report_field("wall_distance", e.wall_distance, g.wall_distance);
                    if (e.slice_height != g.slice_height)
                        report_field("slice_height", e.slice_height, g.slice_height);
                    if (e.row_start != g.row_start)
                        report_field("row_start", e.row_start, g.row_start);
                    if (e.row_end != g.row_end)
                        report_field("row_end", e.row_end, g.row_end);
                    if (e.tex_column != g.tex_column)
                        report_field("tex_column", e.tex_column, g.tex_column);
                end
            end
            pending = expected_setups.size();
        end
    end
endmodule
`default_nettype wire

FILE: tb/raycast_column_setup_core_tb.sv
// top of the raycast column setup testbench: clock, reset, ray and cfg stimulus, verdict
// depends on rcs_pkg, raycast_column_setup_core and raycast_column_setup_checker
`default_nettype none
module raycast_column_setup_core_tb;
    import rcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    wire          s_tready;
    logic [119:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    wire          m_tvalid;
    logic         m_tready = 1'b0;
    wire  [79:0]  m_tdata;
    logic         cfg_valid = 1'b0;
    wire          cfg_ready;
    logic [10:0]  cfg_data = '0;
    int           errors;
    int           pending;
    int           idle_cycles = 0;
    bit           gaps_on = 1'b1;
    bit           hold_request = 1'b0;

    always #4 clk = ~clk;

    raycast_column_setup_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    raycast_column_setup_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // receiver: random stalls, plus one long hold-off on request
    always
    begin
        int n;
        @(posedge clk);
        if (hold_request)
        begin
            m_tready <= 1'b0;
            repeat (400) @(posedge clk);
            hold_request = 1'b0;
        end
        n = gap_len();
        if (n > 0)
        begin
            m_tready <= 1'b0;
            repeat (n - 1) @(posedge clk);
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog on cycles with no word moving anywhere
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic [119:0] pack_ray(logic [11:0] col, logic [7:0] cx, logic [7:0] cy,
                                              logic [1:0] sx, logic [1:0] sy, logic [23:0] camx,
                                              logic [23:0] camy, logic [17:0] rx,
                                              logic [17:0] ry);
        return {4'd0, ry, rx, camy, camx, sy, sx, cy, cx, col};
    endfunction

    task automatic send_ray(logic [119:0] d, logic side);
        int n;
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= side;
        forever
        begin
            @(negedge clk);
            if (s_tready)
                break;
        end
        @(posedge clk);
        n = gap_len();
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_height(logic [10:0] h);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= h;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [1:0] rand_step();
        return $urandom_range(0, 1) ? 2'b01 : 2'b11;
    endfunction

    // well-formed hit: camera inside the map near the wall, sane step and ray; one in ten is random data
    task automatic send_random_ray();
        logic [7:0] cx, cy;
        logic [1:0] sx, sy;
        logic [17:0] rx, ry;
        logic [23:0] camx, camy;
        logic side;
        if ($urandom_range(0, 9) == 0)
        begin
            send_ray({4'd0, 116'($urandom) | (116'($urandom) << 32) | (116'($urandom) << 64)
                      | (116'($urandom) << 96)}, 1'($urandom));
            return;
        end
        cx = 8'($urandom); cy = 8'($urandom);
        sx = rand_step(); sy = rand_step();
        side = 1'($urandom);
        camx = {cx + 8'($signed(sx) * -$urandom_range(0, 6)), 16'($urandom)};
        camy = {cy + 8'($signed(sy) * -$urandom_range(0, 6)), 16'($urandom)};
        rx = 18'($urandom_range(1, 131071));
        ry = 18'($urandom_range(1, 131071));
        if (sx == 2'b11) rx = -rx;
        if (sy == 2'b11) ry = -ry;
        if ($urandom_range(0, 19) == 0) rx = '0;
        if ($urandom_range(0, 19) == 0) ry = '0;
        if ($urandom_range(0, 3) == 0) rx = 18'($urandom_range(0, 15));
        send_ray(pack_ray(12'($urandom), cx, cy, sx, sy, camx, camy, rx, ry), side);
    endtask

    initial
    begin
        logic [10:0] heights[6];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, both sides, mirror cases, saturation and odd steps
        send_ray(pack_ray(12'd0, 8'd5, 8'd5, 2'b01, 2'b01, 24'h048000, 24'h040000,
                          18'h10000, 18'h08000), 1'b0);
        send_ray(pack_ray(12'd4095, 8'd5, 8'd9, 2'b11, 2'b11, 24'h068000, 24'h0A4000,
                          18'h30000, 18'h38000), 1'b1);
        send_ray(pack_ray(12'd1, 8'd5, 8'd5, 2'b11, 2'b01, 24'h068000, 24'h040000,
                          18'h30000, 18'h08000), 1'b0);
        send_ray(pack_ray(12'd2, 8'd5, 8'd9, 2'b01, 2'b01, 24'h044000, 24'h080000,
                          18'h10000, 18'h10000), 1'b1);
        send_ray(pack_ray(12'd3, 8'd9, 8'd0, 2'b01, 2'b01, 24'h000000, 24'h000000,
                          18'h00000, 18'h10000), 1'b0);
        send_ray(pack_ray(12'd4, 8'd0, 8'd0, 2'b01, 2'b01, 24'h000000, 24'h000000,
                          18'h00000, 18'h00000), 1'b0);
        send_ray(pack_ray(12'd5, 8'd255, 8'd255, 2'b01, 2'b01, 24'h000000, 24'h000000,
                          18'h00001, 18'h00001), 1'b0);
        send_ray(pack_ray(12'd6, 8'd0, 8'd0, 2'b01, 2'b01, 24'hFFFFFF, 24'hFFFFFF,
                          18'h1FFFF, 18'h1FFFF), 1'b1);
        send_ray(pack_ray(12'd7, 8'd0, 8'd0, 2'b11, 2'b11, 24'hFFFFFF, 24'hFFFFFF,
                          18'h20000, 18'h20000), 1'b0);
        send_ray(pack_ray(12'd8, 8'd255, 8'd255, 2'b11, 2'b11, 24'h000000, 24'hFFFFFF,
                          18'h20000, 18'h1FFFF), 1'b1);
        send_ray(pack_ray(12'd9, 8'd4, 8'd4, 2'b00, 2'b10, 24'h030000, 24'h030000,
                          18'h10000, 18'h10000), 1'b0);
        send_ray(pack_ray(12'd10, 8'd4, 8'd4, 2'b10, 2'b00, 24'h030000, 24'h030000,
                          18'h10000, 18'h10000), 1'b1);
        send_ray(pack_ray(12'd11, 8'd3, 8'd3, 2'b01, 2'b01, 24'h038000, 24'h038000,
                          18'h10000, 18'h10000), 1'b0);
        send_ray(pack_ray(12'd12, 8'd3, 8'd3, 2'b01, 2'b01, 24'h038000, 24'h038000,
                          18'h10000, 18'h10000), 1'b1);
        send_ray(pack_ray(12'd13, 8'd3, 8'd3, 2'b01, 2'b01, 24'h038001, 24'h030000,
                          18'h1FFFF, 18'h20000), 1'b0);
        send_ray(pack_ray(12'd14, 8'd200, 8'd3, 2'b01, 2'b01, 24'h000000, 24'h000000,
                          18'h00001, 18'h20000), 1'b0);

        heights = '{11'd0, 11'd1, 11'd2047, 11'd2, 11'd480, 11'd0};
        heights[5] = 11'($urandom_range(3, 2046));
        for (int p = 0; p < 6; p++)
        begin
            write_height(heights[p]);
            gaps_on = (p != 3);
            if (p == 2)
                hold_request = 1'b1;
            for (int i = 0; i < 235; i++)
                send_random_ray();
            if (p == 1)
                wait_drained();
        end
        write_height(11'($urandom_range(1, 2047)));
        for (int i = 0; i < 40; i++)
            send_random_ray();

        wait_drained();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
